// ===== hdl/rhd_pkg.sv =====
// Shared constants, codes and types for the rod heat diffusion step block.
// Depends on nothing; the design files refer to it by scoped names, the testbench imports it.

package rhd_pkg;

   // Storage size of the rod and the widths that follow from it.
   localparam int MAX_POINTS = 128;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int MIN_POINTS = 3;

   // Fixed field widths.
   localparam int OP_W      = 2;
   localparam int IDX_W     = 7;
   localparam int GAIN_W    = 16;
   localparam int TEMP_W    = 19;
   localparam int POINTS_W  = 8;
   localparam int CSR_IDX_W = 2;

   // Datapath widths of one interior update.
   localparam int LAP_W  = TEMP_W + 2;
   localparam int PROD_W = LAP_W + GAIN_W + 1;
   localparam int FRAC_W = 16;
   localparam int INC_W  = PROD_W - FRAC_W;
   localparam int SUM_W  = INC_W + 1;

   localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(2 ** (FRAC_W - 1));

   localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W - 1){1'b1}}};
   localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W - 1){1'b0}}};

   // Register reset values.
   localparam logic [POINTS_W-1:0]      POINTS_RESET  = POINTS_W'(100);
   localparam logic signed [TEMP_W-1:0] SOURCE_RESET  = TEMP_W'(6400);
   localparam logic signed [TEMP_W-1:0] AMBIENT_RESET = TEMP_W'(1280);

   // Operation codes.
   localparam logic [OP_W-1:0] OP_REINIT  = 2'd0;
   localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ    = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_POINTS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AMBIENT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_EDGE_SRC,
      ST_EDGE_AMB,
      ST_READ
   } seq_state_type;

endpackage

// ===== hdl/rhd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Self-contained; holds the rod temperatures of the diffusion block.

module rhd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== hdl/rod_heat_diffusion_step.sv =====
// Rod heat diffusion step: keeps a rod of up to 128 temperatures in a RAM and applies one
// explicit three-point diffusion step per advance transfer. A reinit transfer ends as it is
// accepted, a read transfer when its result is loaded (after any wait for the result channel),
// and in an advance transfer over n simulated points the sweep reads each of the n points once
// through the single RAM read port, and one shared multiply pipeline updates one interior
// point per cycle behind it, followed by two boundary writes. The input channel is not ready
// while an item is at work. After reset the rod reads as source at point 0 and ambient
// elsewhere at once; per-point valid flags supply these values until a point is written.

module rod_heat_diffusion_step (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [rhd_pkg::OP_W-1:0]             req_operation,
   input  logic [rhd_pkg::IDX_W-1:0]            req_point_index,
   input  logic [rhd_pkg::GAIN_W-1:0]           req_step_gain,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [rhd_pkg::TEMP_W-1:0]    rsp_temperature,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rhd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rhd_pkg::TEMP_W-1:0]           csr_data
);

   localparam int ADDR_W = rhd_pkg::ADDR_W;
   localparam int CNT_W  = rhd_pkg::CNT_W;
   localparam int TEMP_W = rhd_pkg::TEMP_W;
   localparam int LAP_W  = rhd_pkg::LAP_W;
   localparam int PROD_W = rhd_pkg::PROD_W;
   localparam int INC_W  = rhd_pkg::INC_W;
   localparam int SUM_W  = rhd_pkg::SUM_W;

   // Sequencer.
   rhd_pkg::seq_state_type state_ff, state_in;

   // Configuration registers.
   logic [rhd_pkg::POINTS_W-1:0] points_ff;
   logic signed [TEMP_W-1:0]     source_ff;
   logic signed [TEMP_W-1:0]     ambient_ff;

   // Values that unwritten points read as; captured at reset and at each reinit.
   logic signed [TEMP_W-1:0]     init_src_ff;
   logic signed [TEMP_W-1:0]     init_amb_ff;
   logic [rhd_pkg::MAX_POINTS-1:0] pt_valid_ff;

   // Per-item parameters and the sweep counter.
   logic [CNT_W-1:0]             n_ff;
   logic [CNT_W-1:0]             n_in;
   logic [rhd_pkg::GAIN_W-1:0]   gain_ff;
   logic [ADDR_W-1:0]            rd_cnt_ff, rd_cnt_in;

   // RAM ports.
   logic                         rd_en;
   logic [ADDR_W-1:0]            rd_addr;
   logic [TEMP_W-1:0]            ram_q;
   logic                         wr_en;
   logic [ADDR_W-1:0]            wr_addr;
   logic signed [TEMP_W-1:0]     wr_data;

   // Sequencer outputs.
   logic                         sweep_rd;
   logic                         edge_wr;
   logic [ADDR_W-1:0]            edge_addr;
   logic signed [TEMP_W-1:0]     edge_data;
   logic                         rsp_load;
   logic                         pipe_busy;

   // Read tag stage, aligned with the RAM read data.
   logic                         s0_adv_ff;
   logic [ADDR_W-1:0]            s0_addr_ff;
   logic                         s0_vld_ff;
   logic                         s0_oob_ff;
   logic signed [TEMP_W-1:0]     rd_value;

   // Three-point window and the update pipeline.
   logic signed [TEMP_W-1:0]     w_l_ff, w_c_ff, w_r_ff;
   logic                         s1_v_ff;
   logic [ADDR_W-1:0]            s1_addr_ff;
   logic signed [LAP_W-1:0]      lap_ff;
   logic signed [TEMP_W-1:0]     c2_ff;
   logic                         s2_v_ff;
   logic [ADDR_W-1:0]            s2_addr_ff;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [TEMP_W-1:0]     c3_ff;
   logic                         s3_v_ff;
   logic [ADDR_W-1:0]            s3_addr_ff;
   logic signed [PROD_W-1:0]     rnd;
   logic signed [INC_W-1:0]      inc_ff;
   logic signed [TEMP_W-1:0]     c4_ff;
   logic                         s4_v_ff;
   logic [ADDR_W-1:0]            s4_addr_ff;
   logic signed [SUM_W-1:0]      sum;
   logic signed [TEMP_W-1:0]     upd_value;

   // Result register.
   logic                         rsp_valid_ff;
   logic signed [TEMP_W-1:0]     rsp_temp_ff;

   logic                         req_fire;

   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_temperature = rsp_temp_ff;

   // The simulated length is clamped to the legal range when an advance is accepted.
   always_comb begin
      if (points_ff < rhd_pkg::POINTS_W'(rhd_pkg::MIN_POINTS)) begin
         n_in = CNT_W'(rhd_pkg::MIN_POINTS);
      end else if (32'(points_ff) > 32'(rhd_pkg::MAX_POINTS)) begin
         n_in = CNT_W'(rhd_pkg::MAX_POINTS);
      end else begin
         n_in = CNT_W'(points_ff);
      end
   end

   assign pipe_busy = s0_adv_ff || s1_v_ff || s2_v_ff || s3_v_ff || s4_v_ff;

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rhd_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_operation)
                  rhd_pkg::OP_ADVANCE: state_in = rhd_pkg::ST_SWEEP;
                  rhd_pkg::OP_READ:    state_in = rhd_pkg::ST_READ;
                  rhd_pkg::OP_REINIT:  state_in = rhd_pkg::ST_IDLE;
                  rhd_pkg::OP_UNUSED:  state_in = rhd_pkg::ST_IDLE;
               endcase
            end
         end
         rhd_pkg::ST_SWEEP: begin
            if (rd_cnt_ff == ADDR_W'(n_ff - CNT_W'(1))) begin
               state_in = rhd_pkg::ST_DRAIN;
            end
         end
         rhd_pkg::ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = rhd_pkg::ST_EDGE_SRC;
            end
         end
         rhd_pkg::ST_EDGE_SRC: state_in = rhd_pkg::ST_EDGE_AMB;
         rhd_pkg::ST_EDGE_AMB: state_in = rhd_pkg::ST_IDLE;
         rhd_pkg::ST_READ: begin
            if (rsp_load) begin
               state_in = rhd_pkg::ST_IDLE;
            end
         end
         default: state_in = rhd_pkg::ST_IDLE;
      endcase
   end

   // Output logic of the sequencer.
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = rd_cnt_ff;
      sweep_rd  = 1'b0;
      edge_wr   = 1'b0;
      edge_addr = '0;
      edge_data = source_ff;
      rsp_load  = 1'b0;
      rd_cnt_in = rd_cnt_ff;
      unique case (state_ff)
         rhd_pkg::ST_IDLE: begin
            // A read is issued in the cycle it is accepted; the sweep restarts at point 0.
            req_ready = 1'b1;
            rd_en     = req_valid && (req_operation == rhd_pkg::OP_READ);
            rd_addr   = ADDR_W'(req_point_index);
            rd_cnt_in = '0;
         end
         rhd_pkg::ST_SWEEP: begin
            rd_en     = 1'b1;
            sweep_rd  = 1'b1;
            rd_cnt_in = rd_cnt_ff + ADDR_W'(1);
         end
         rhd_pkg::ST_DRAIN: begin
            rd_en = 1'b0;
         end
         rhd_pkg::ST_EDGE_SRC: begin
            edge_wr   = 1'b1;
            edge_addr = '0;
            edge_data = source_ff;
         end
         rhd_pkg::ST_EDGE_AMB: begin
            edge_wr   = 1'b1;
            edge_addr = ADDR_W'(n_ff - CNT_W'(1));
            edge_data = ambient_ff;
         end
         rhd_pkg::ST_READ: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // A point never written since the last reinit reads as the value the rod was loaded with.
   always_comb begin
      if (s0_oob_ff) begin
         rd_value = '0;
      end else if (s0_vld_ff) begin
         rd_value = $signed(ram_q);
      end else if (s0_addr_ff == '0) begin
         rd_value = init_src_ff;
      end else begin
         rd_value = init_amb_ff;
      end
   end

   // Rounding to nearest, half up, then saturation of the updated point.
   assign rnd = prod_ff + rhd_pkg::ROUND_BIAS;
   assign sum = SUM_W'(c4_ff) + SUM_W'(inc_ff);

   always_comb begin
      if (sum > SUM_W'(rhd_pkg::TEMP_MAX)) begin
         upd_value = rhd_pkg::TEMP_MAX;
      end else if (sum < SUM_W'(rhd_pkg::TEMP_MIN)) begin
         upd_value = rhd_pkg::TEMP_MIN;
      end else begin
         upd_value = TEMP_W'(sum);
      end
   end

   // Interior updates and boundary writes never overlap: the boundaries follow the drain.
   assign wr_en   = s4_v_ff || edge_wr;
   assign wr_addr = s4_v_ff ? s4_addr_ff : edge_addr;
   assign wr_data = s4_v_ff ? upd_value : edge_data;

   rhd_ram #(
      .WIDTH(TEMP_W),
      .DEPTH(rhd_pkg::MAX_POINTS)
   ) u_rod_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(ram_q)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rhd_pkg::ST_IDLE;
         points_ff    <= rhd_pkg::POINTS_RESET;
         source_ff    <= rhd_pkg::SOURCE_RESET;
         ambient_ff   <= rhd_pkg::AMBIENT_RESET;
         init_src_ff  <= rhd_pkg::SOURCE_RESET;
         init_amb_ff  <= rhd_pkg::AMBIENT_RESET;
         pt_valid_ff  <= '0;
         rd_cnt_ff    <= '0;
         s0_adv_ff    <= 1'b0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         s4_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_cnt_ff <= rd_cnt_in;

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               rhd_pkg::CSR_POINTS:  points_ff  <= csr_data[rhd_pkg::POINTS_W-1:0];
               rhd_pkg::CSR_SOURCE:  source_ff  <= $signed(csr_data);
               rhd_pkg::CSR_AMBIENT: ambient_ff <= $signed(csr_data);
               default: ;
            endcase
         end

         // A reinit reloads the whole rod at once by dropping every written flag.
         if (req_fire && (req_operation == rhd_pkg::OP_REINIT)) begin
            init_src_ff <= source_ff;
            init_amb_ff <= ambient_ff;
            pt_valid_ff <= '0;
         end else if (wr_en) begin
            pt_valid_ff[wr_addr] <= 1'b1;
         end

         s0_adv_ff <= sweep_rd;
         s1_v_ff   <= s0_adv_ff && (s0_addr_ff >= ADDR_W'(2));
         s2_v_ff   <= s1_v_ff;
         s3_v_ff   <= s2_v_ff;
         s4_v_ff   <= s3_v_ff;

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire && (req_operation == rhd_pkg::OP_ADVANCE)) begin
         n_ff    <= n_in;
         gain_ff <= req_step_gain;
      end

      if (rd_en) begin
         s0_addr_ff <= rd_addr;
         s0_vld_ff  <= pt_valid_ff[rd_addr];
         s0_oob_ff  <= !sweep_rd && (32'(req_point_index) >= 32'(rhd_pkg::MAX_POINTS));
      end

      // The window slides by one point for each value the sweep returns.
      if (s0_adv_ff) begin
         w_l_ff <= w_c_ff;
         w_c_ff <= w_r_ff;
         w_r_ff <= rd_value;
      end
      s1_addr_ff <= s0_addr_ff - ADDR_W'(1);

      lap_ff     <= LAP_W'(w_r_ff) + LAP_W'(w_l_ff) - (LAP_W'(w_c_ff) <<< 1);
      c2_ff      <= w_c_ff;
      s2_addr_ff <= s1_addr_ff;

      prod_ff    <= lap_ff * $signed({1'b0, gain_ff});
      c3_ff      <= c2_ff;
      s3_addr_ff <= s2_addr_ff;

      inc_ff     <= $signed(rnd[rhd_pkg::FRAC_W +: INC_W]);
      c4_ff      <= c3_ff;
      s4_addr_ff <= s3_addr_ff;

      if (rsp_load) begin
         rsp_temp_ff <= rd_value;
      end
   end

endmodule

// ===== hdl/rhd_checker.sv =====
// Port-level checks for the rod heat diffusion step block, and the bind that attaches them.
// Depends on rhd_pkg for operation codes and field widths.

module rhd_port_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [rhd_pkg::OP_W-1:0]          req_operation,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [rhd_pkg::TEMP_W-1:0] rsp_temperature
);

   // A result that is not taken holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temperature))
      else $error("result changed or dropped while stalled");

   // Reset leaves the block ready with no result pending.
   assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

   // An accepted advance keeps the input side closed for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == rhd_pkg::OP_ADVANCE) |=> !req_ready)
      else $error("input accepted during an advance sweep");

   // Reinit and the unused code finish at once.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      ((req_operation == rhd_pkg::OP_REINIT) || (req_operation == rhd_pkg::OP_UNUSED))
      |=> req_ready)
      else $error("reinit or unused code held the input side");

   // A read into a free result register shows its result once the RAM data is in the result register.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == rhd_pkg::OP_READ) && !rsp_valid
      |-> ##2 rsp_valid)
      else $error("read produced no result");

endmodule

bind rod_heat_diffusion_step rhd_port_checker u_rhd_checker (.*);

// ===== tb/sv/rhd_checker.sv =====
`timescale 1ns / 1ps
// Temperature predictor and result checker for the rod heat diffusion step block.
// Depends on rhd_pkg; it only watches the request, result and register channels.

module rhd_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [rhd_pkg::OP_W-1:0]          req_operation,
   input  logic [rhd_pkg::IDX_W-1:0]         req_point_index,
   input  logic [rhd_pkg::GAIN_W-1:0]        req_step_gain,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [rhd_pkg::TEMP_W-1:0] rsp_temperature,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [rhd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rhd_pkg::TEMP_W-1:0]        csr_data,
   output int                                fail_count,
   output int                                temps_awaited
);

   import rhd_pkg::*;

   localparam longint TEMP_LO      = TEMP_MIN;
   localparam longint TEMP_HI      = TEMP_MAX;
   localparam int     REPORT_LIMIT = 10;

   logic signed [TEMP_W-1:0] rod_model [MAX_POINTS];
   logic [POINTS_W-1:0]      points_reg;
   logic signed [TEMP_W-1:0] source_reg;
   logic signed [TEMP_W-1:0] ambient_reg;
   logic signed [TEMP_W-1:0] temps_due [$];
   logic signed [TEMP_W-1:0] due_temp;
   int                       mismatches = 0;

   task automatic reload_rod();
      for (int i = 0; i < MAX_POINTS; i++)
         rod_model[i] = ambient_reg;
      rod_model[0] = source_reg;
   endtask

   // One explicit step over the interior, computed from the values before the step, then the two boundary writes.
   task automatic diffuse_step(input logic [GAIN_W-1:0] gain);
      logic signed [TEMP_W-1:0] prior [MAX_POINTS];
      longint gain_l;
      longint left;
      longint centre;
      longint right;
      longint delta;
      longint updated;
      int     n;
      n = int'(points_reg);
      if (n < MIN_POINTS)
         n = MIN_POINTS;
      if (n > MAX_POINTS)
         n = MAX_POINTS;
      gain_l = longint'(gain);
      prior  = rod_model;
      for (int i = 1; i + 1 < n; i++) begin
         left   = longint'(prior[i - 1]);
         centre = longint'(prior[i]);
         right  = longint'(prior[i + 1]);
         // Half is added before the arithmetic shift, so the increment rounds half up.
         delta   = ((right - 2 * centre + left) * gain_l + 32768) >>> FRAC_W;
         updated = centre + delta;
         if (updated < TEMP_LO)
            updated = TEMP_LO;
         else if (updated > TEMP_HI)
            updated = TEMP_HI;
         rod_model[i] = updated[TEMP_W-1:0];
      end
      rod_model[0]     = source_reg;
      rod_model[n - 1] = ambient_reg;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         points_reg  = POINTS_RESET;
         source_reg  = SOURCE_RESET;
         ambient_reg = AMBIENT_RESET;
         reload_rod();
         temps_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (temps_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected temperature transfer, got %0d", $time,
                           rsp_temperature);
            end else begin
               due_temp = temps_due.pop_front();
               if (rsp_temperature !== due_temp) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("%0t: temperature wrong, expected %0d, got %0d", $time,
                              due_temp, rsp_temperature);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_POINTS:  points_reg  = csr_data[POINTS_W-1:0];
               CSR_SOURCE:  source_reg  = csr_data;
               CSR_AMBIENT: ambient_reg = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_operation)
               OP_REINIT:  reload_rod();
               OP_ADVANCE: diffuse_step(req_step_gain);
               OP_READ:    temps_due.push_back(rod_model[req_point_index]);
               default: ;
            endcase
         end
      end
      temps_awaited <= temps_due.size();
      fail_count    <= mismatches;
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Top of the rod heat diffusion step testbench: clock, reset, stimulus and verdict.
// Depends on rhd_pkg, the block itself and rhd_checker, which predicts and compares.

module tb;

   import rhd_pkg::*;

   // The run is bounded well above the slowest legal run, which is roughly 1300 items
   // each taking a full 128 point advance plus the longest gaps on both sides.
   localparam int CYCLE_LIMIT     = 1_000_000;
   // An advance gives no result, so this wait covers a trailing advance of the largest rod.
   localparam int SETTLE_CYCLES   = MAX_POINTS + 40;
   localparam int LONG_HOLD       = 400;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 160;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [OP_W-1:0]          req_operation;
   logic [IDX_W-1:0]         req_point_index;
   logic [GAIN_W-1:0]        req_step_gain;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [TEMP_W-1:0] rsp_temperature;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [TEMP_W-1:0]        csr_data;

   int fail_count;
   int temps_awaited;
   int cycle_count;

   // Idling controls for the sender and the receiver; both are cleared for the
   // final phase so that the last part of the run goes at full rate.
   bit req_idling       = 1'b1;
   bit rsp_idling       = 1'b1;
   bit hold_off_request = 1'b0;

   rod_heat_diffusion_step DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_point_index (req_point_index),
      .req_step_gain   (req_step_gain),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_temperature (rsp_temperature),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   rhd_checker temp_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_point_index (req_point_index),
      .req_step_gain   (req_step_gain),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_temperature (rsp_temperature),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .temps_awaited   (temps_awaited)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a run that has not finished by the limit is a failure.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Result side. Ready changes only at falling edges. Short random stalls alternate
   // with stretches of ready, and once the stimulus asks for it the receiver holds off
   // for a long stretch so that the block fills up and stops taking requests.
   initial begin : receiver
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (rsp_idling && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_idling)
               repeat ($urandom_range(0, 15)) @(negedge clock);
         end
      end
   end

   // Offers one request and returns at the rising edge of its transfer. Valid is left
   // high, so a following request goes out back to back unless a gap is drawn.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                            input logic [GAIN_W-1:0] gain);
      @(negedge clock);
      if (req_idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_point_index <= idx;
      req_step_gain   <= gain;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [TEMP_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stops offering requests and waits for every outstanding read result.
   task automatic await_results();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (temps_awaited != 0) @(posedge clock);
   endtask

   // As above, then lets a trailing advance finish so that the block is idle.
   task automatic settle();
      await_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random request: mostly advances and reads, with the odd reinit and unused code.
   // Reads favour the simulated points but still reach beyond them.
   task automatic random_item(input int n);
      int                pick;
      logic [OP_W-1:0]   op;
      logic [IDX_W-1:0]  idx;
      logic [GAIN_W-1:0] gain;
      pick = int'($urandom_range(0, 99));
      idx  = IDX_W'($urandom);
      gain = GAIN_W'($urandom);
      if (pick < 4)
         op = OP_REINIT;
      else if (pick < 40)
         op = OP_ADVANCE;
      else if (pick < 97)
         op = OP_READ;
      else
         op = OP_UNUSED;
      if (op == OP_READ && $urandom_range(0, 3) != 0)
         idx = IDX_W'($urandom_range(0, n - 1));
      if (op == OP_ADVANCE) begin
         case ($urandom_range(0, 9))
            0: gain = '0;
            1: gain = GAIN_W'(32768);
            2: gain = GAIN_W'($urandom_range(0, 1023));
            3: ;
            default: gain = GAIN_W'($urandom_range(0, 32768));
         endcase
      end
      send_item(op, idx, gain);
   endtask

   initial begin : stimulus
      int                       n;
      logic [POINTS_W-1:0]      pts;
      logic signed [TEMP_W-1:0] src;
      logic signed [TEMP_W-1:0] amb;
      logic [TEMP_W-1:0]        word;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = OP_REINIT;
      req_point_index = '0;
      req_step_gain   = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_POINTS;
      csr_data        = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset settings: the rod straight out of reset, gains of
      // zero, the stability limit and the largest code, the unused operation, a read of the
      // fixed last point and one beyond the rod, and a reinit.
      send_item(OP_READ, 7'd0, '0);
      send_item(OP_READ, 7'd1, '0);
      send_item(OP_READ, 7'd127, '0);
      send_item(OP_ADVANCE, '0, '0);
      send_item(OP_READ, 7'd1, '0);
      send_item(OP_ADVANCE, '0, GAIN_W'(32768));
      send_item(OP_READ, 7'd1, '0);
      send_item(OP_READ, 7'd99, '0);
      send_item(OP_UNUSED, 7'd127, 16'hFFFF);
      send_item(OP_ADVANCE, '0, 16'hFFFF);
      send_item(OP_READ, 7'd2, '0);
      send_item(OP_REINIT, '0, '0);
      send_item(OP_READ, 7'd50, '0);

      // Smallest rod between the temperature extremes, with an over-limit gain on the
      // single interior point; reads beyond the rod too.
      settle();
      write_register(CSR_POINTS, TEMP_W'(MIN_POINTS));
      write_register(CSR_SOURCE, TEMP_MAX);
      write_register(CSR_AMBIENT, TEMP_MIN);
      send_item(OP_ADVANCE, '0, 16'hFFFF);
      send_item(OP_READ, 7'd1, '0);
      send_item(OP_ADVANCE, '0, GAIN_W'(32768));
      send_item(OP_READ, 7'd1, '0);
      send_item(OP_READ, 7'd127, '0);
      send_item(OP_REINIT, '0, '0);
      send_item(OP_READ, 7'd127, '0);
      send_item(OP_READ, 7'd0, '0);
      send_item(OP_ADVANCE, '0, '0);
      send_item(OP_READ, 7'd2, '0);

      // Random phases, each under its own register settings. Point counts below three
      // and above the storage size are clamped by the block.
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         src = TEMP_W'($urandom);
         amb = TEMP_W'($urandom);
         case (phase)
            0: begin
               pts = POINTS_W'(MAX_POINTS);
               src = TEMP_MIN;
               amb = TEMP_MAX;
            end
            1: pts = 8'hFF;
            2: pts = 8'h00;
            3: pts = POINTS_W'($urandom_range(1, 2));
            4: pts = POINTS_W'($urandom_range(MIN_POINTS, MAX_POINTS));
            5: pts = POINTS_W'($urandom_range(MIN_POINTS, 24));
            6: begin
               pts = POINTS_RESET;
               src = SOURCE_RESET;
               amb = AMBIENT_RESET;
            end
            default: begin
               pts = POINTS_W'($urandom_range(MIN_POINTS, MAX_POINTS));
               src = TEMP_MAX;
               amb = TEMP_MAX;
            end
         endcase
         // Bits above the point count are written at random; the block ignores them.
         word                 = TEMP_W'($urandom);
         word[POINTS_W-1:0]   = pts;
         write_register(CSR_POINTS, word);
         write_register(CSR_SOURCE, src);
         write_register(CSR_AMBIENT, amb);

         n = int'(pts);
         if (n < MIN_POINTS)
            n = MIN_POINTS;
         if (n > MAX_POINTS)
            n = MAX_POINTS;

         if (phase == PHASES - 1) begin
            req_idling = 1'b0;
            rsp_idling = 1'b0;
         end
         if (phase == 1)
            hold_off_request = 1'b1;

         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            // Halfway through one phase the sender pauses until every read has returned.
            if (phase == 3 && k == ITEMS_PER_PHASE / 2)
               await_results();
            random_item(n);
         end
      end

      settle();
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/rhd_pkg.sv
hdl/rhd_ram.sv
hdl/rod_heat_diffusion_step.sv
hdl/rhd_checker.sv
tb/sv/rhd_checker.sv
tb/sv/tb.sv
